@@ hdl/kde_pkg.sv @@
// Shared types and constants of the key debounce and event detector.
package kde_pkg;

	localparam int STEP_W      = 8;
	localparam int CFG_W       = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int KIND_W      = 2;
	localparam int KEY_W       = 2;
	localparam int PIN_BITS    = 4;
	localparam int MASK_BITS   = 4;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_SCAN          = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TAKE_PRESSED  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TAKE_RELEASED = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SCAN_STEP     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PRESSED_HOLD  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RELEASED_HOLD = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS    = 3'd4;

	// register reset values
	localparam logic [STEP_W-1:0] RST_SCAN_STEP     = 8'd10;
	localparam logic [CFG_W-1:0]  RST_DEBOUNCE      = 16'd20;
	localparam logic [CFG_W-1:0]  RST_PRESSED_HOLD  = 16'd200;
	localparam logic [CFG_W-1:0]  RST_RELEASED_HOLD = 16'd200;
	localparam logic [CFG_W-1:0]  RST_LONG_PRESS    = 16'd1000;

	typedef struct packed {
		logic [STEP_W-1:0] scan_step;
		logic [CFG_W-1:0]  debounce;
		logic [CFG_W-1:0]  pressed_hold;
		logic [CFG_W-1:0]  released_hold;
		logic [CFG_W-1:0]  long_hold;
	} kde_cfg_t;

	typedef struct packed {
		logic enable;
		logic scan;
		logic take_pressed;
		logic take_released;
	} kde_cmd_t;

	typedef struct packed {
		logic down;
		logic pressed;
		logic released;
		logic held_long;
		logic taken;
	} kde_flags_t;

	typedef struct packed {
		logic                 taken;
		logic [MASK_BITS-1:0] long_mask;
		logic [MASK_BITS-1:0] released_mask;
		logic [MASK_BITS-1:0] pressed_mask;
		logic [MASK_BITS-1:0] down_mask;
	} kde_result_t;

	localparam int RESULT_W = $bits(kde_result_t);
	localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

@@ hdl/key_debounce_event_detector.sv @@
// Top level of the key debounce and event detector.
//
// Channels: an input stream (s_tvalid/s_tready/s_tdata/s_tuser) carries one
// transaction per item. s_tuser holds the item kind: scan tick, take pressed
// flag or take released flag. A scan tick brings every raw pin level at once
// (low means pressed); a take names one key and clears its one-shot flag.
// The output stream (m_*) returns exactly one result per item: the debounced
// down mask, the pending pressed and released masks, the long-press mask and
// a taken bit, all as they stand after that item.
// Configuration writes go through cfg_valid/cfg_ready with an index and data;
// cfg_ready is always high. Write only while no item is in flight.
// An accepted item is held in the input register; the per-key update then
// loads the result register from it. Throughput: one item per cycle while
// m_tready allows, set by the single per-key update between those two
// registers.
// Reset: every key released, all flags and counters zero, registers at their
// default values, both stages empty.
// Stall: a result held by a low m_tready stays put; one more item waits in
// the input register, after which s_tready drops until the result drains.
module key_debounce_event_detector
	import kde_pkg::*;
#(
	parameter int NUM_KEYS    = 4,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // key_index [1:0], raw_pins [5:2]
	input  logic [KIND_W-1:0]      s_tuser,   // kind [1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,   // down_mask [3:0], pressed_mask [7:4],
	                                          // released_mask [11:8], long_mask [15:12],
	                                          // taken [16]
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	kde_cfg_t cfg;

	assign cfg_ready = 1'b1;

	kde_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Input register stage.
	logic                valid_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic [KEY_W-1:0]    key_s1;
	logic [PIN_BITS-1:0] pins_s1;

	// Result register.
	logic        out_valid_q;
	kde_result_t result_q;

	logic advance;

	// Advance the input stage whenever the result register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			key_s1  <= s_tdata[KEY_W-1:0];
			pins_s1 <= s_tdata[KEY_W+PIN_BITS-1:KEY_W];
		end
	end

	// Per-key update.
	kde_flags_t           flags_next [NUM_KEYS];
	logic [NUM_KEYS-1:0]  taken_vec;
	kde_result_t          result_next;

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		kde_cmd_t cmd;
		logic     raw_down;
		logic     addressed;

		if (k < PIN_BITS) begin : g_pin
			// pins are active low
			assign raw_down  = !pins_s1[k];
			assign addressed = (key_s1 == KEY_W'(k));
		end else begin : g_no_pin
			// no pin: reads high, i.e. released, and cannot be addressed
			assign raw_down  = 1'b0;
			assign addressed = 1'b0;
		end

		assign cmd.enable        = advance;
		assign cmd.scan          = kind_s1 == KIND_SCAN;
		assign cmd.take_pressed  = addressed && (kind_s1 == KIND_TAKE_PRESSED);
		assign cmd.take_released = addressed && (kind_s1 == KIND_TAKE_RELEASED);

		kde_key_cell #(
			.COUNT_WIDTH (COUNT_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cfg        (cfg),
			.cmd        (cmd),
			.raw_down   (raw_down),
			.flags_next (flags_next[k])
		);

		assign taken_vec[k] = flags_next[k].taken;
	end

	// Gather the masks; only the first keys fit the mask width.
	for (genvar m = 0; m < MASK_BITS; m++) begin : g_mask
		if (m < NUM_KEYS) begin : g_live
			assign result_next.down_mask[m]     = flags_next[m].down;
			assign result_next.pressed_mask[m]  = flags_next[m].pressed;
			assign result_next.released_mask[m] = flags_next[m].released;
			assign result_next.long_mask[m]     = flags_next[m].held_long;
		end else begin : g_pad
			assign result_next.down_mask[m]     = 1'b0;
			assign result_next.pressed_mask[m]  = 1'b0;
			assign result_next.released_mask[m] = 1'b0;
			assign result_next.long_mask[m]     = 1'b0;
		end
	end

	assign result_next.taken = |taken_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(result_q);

`ifndef SYNTHESIS
	// A scan tick never reports a taken flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (kind_s1 == KIND_SCAN) |=> !result_q.taken)
		else $error("taken set on a scan tick");

	// Long press only on a key that is down.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((result_q.long_mask & ~result_q.down_mask) == '0))
		else $error("long press on a released key");

	// Input back-pressure only when both stages hold data and the sink stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without cause");

	// Every advanced item produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item lost");
`endif

endmodule

@@ hdl/kde_cfg_regs.sv @@
// Configuration register file of the key debounce and event detector.
module kde_cfg_regs
	import kde_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]       wr_data,
	output kde_cfg_t               cfg
);

	kde_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_step     <= RST_SCAN_STEP;
			cfg_q.debounce      <= RST_DEBOUNCE;
			cfg_q.pressed_hold  <= RST_PRESSED_HOLD;
			cfg_q.released_hold <= RST_RELEASED_HOLD;
			cfg_q.long_hold     <= RST_LONG_PRESS;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SCAN_STEP:     cfg_q.scan_step     <= wr_data[STEP_W-1:0];
				REG_DEBOUNCE:      cfg_q.debounce      <= wr_data;
				REG_PRESSED_HOLD:  cfg_q.pressed_hold  <= wr_data;
				REG_RELEASED_HOLD: cfg_q.released_hold <= wr_data;
				REG_LONG_PRESS:    cfg_q.long_hold     <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/kde_key_cell.sv @@
// Per-key debounce filter, one-shot flags and long-press timer.
module kde_key_cell
	import kde_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  kde_cfg_t   cfg,
	input  kde_cmd_t   cmd,
	input  logic       raw_down,
	output kde_flags_t flags_next
);

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	function automatic logic [COUNT_WIDTH-1:0] sat_add(
		input logic [COUNT_WIDTH-1:0] c,
		input logic [STEP_W-1:0]      s
	);
		logic [COUNT_WIDTH:0] sum;
		sum = {1'b0, c} + (COUNT_WIDTH + 1)'(s);
		return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
	endfunction

	function automatic logic reached(
		input logic [COUNT_WIDTH-1:0] c,
		input logic [CFG_W-1:0]       th
	);
		return CMP_W'(c) >= CMP_W'(th);
	endfunction

	logic                   stable_q, pf_q, rf_q, lf_q;
	logic [COUNT_WIDTH-1:0] deb_q, hold_q, page_q, rage_q;

	logic                   stable_n, pf_n, rf_n, lf_n, taken_n;
	logic [COUNT_WIDTH-1:0] deb_n, hold_n, page_n, rage_n;
	logic [COUNT_WIDTH-1:0] deb_sum, hold_sum, page_base, rage_base, page_sum, rage_sum;
	logic                   rise, fall, pf_set, rf_set;

	// The previous level always equals the stable level between scans,
	// so stable_q serves as the edge reference.
	always_comb begin
		stable_n  = stable_q;
		deb_n     = deb_q;
		pf_n      = pf_q;
		rf_n      = rf_q;
		lf_n      = lf_q;
		hold_n    = hold_q;
		page_n    = page_q;
		rage_n    = rage_q;
		taken_n   = 1'b0;
		deb_sum   = sat_add(deb_q, cfg.scan_step);
		hold_sum  = sat_add(hold_q, cfg.scan_step);
		rise      = 1'b0;
		fall      = 1'b0;
		if (cmd.scan) begin
			if (raw_down == stable_q) begin
				deb_n = '0;
			end else begin
				deb_n = deb_sum;
				if (reached(deb_sum, cfg.debounce)) begin
					stable_n = raw_down;
					deb_n    = '0;
				end
			end
			rise = !stable_q && stable_n;
			fall = stable_q && !stable_n;
		end
		pf_set    = pf_q | rise;
		rf_set    = rf_q | fall;
		page_base = rise ? '0 : page_q;
		rage_base = fall ? '0 : rage_q;
		page_sum  = sat_add(page_base, cfg.scan_step);
		rage_sum  = sat_add(rage_base, cfg.scan_step);
		if (cmd.scan) begin
			pf_n   = pf_set;
			page_n = page_base;
			if (pf_set) begin
				page_n = page_sum;
				if (reached(page_sum, cfg.pressed_hold)) begin
					pf_n = 1'b0;
				end
			end
			rf_n   = rf_set;
			rage_n = rage_base;
			if (rf_set) begin
				rage_n = rage_sum;
				if (reached(rage_sum, cfg.released_hold)) begin
					rf_n = 1'b0;
				end
			end
			if (stable_n) begin
				hold_n = hold_sum;
				if (reached(hold_sum, cfg.long_hold)) begin
					lf_n = 1'b1;
				end
			end else begin
				hold_n = '0;
				lf_n   = 1'b0;
			end
		end else begin
			taken_n = (cmd.take_pressed && pf_q) || (cmd.take_released && rf_q);
			pf_n    = pf_q && !cmd.take_pressed;
			rf_n    = rf_q && !cmd.take_released;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b0;
			pf_q     <= 1'b0;
			rf_q     <= 1'b0;
			lf_q     <= 1'b0;
			deb_q    <= '0;
			hold_q   <= '0;
			page_q   <= '0;
			rage_q   <= '0;
		end else if (cmd.enable) begin
			stable_q <= stable_n;
			pf_q     <= pf_n;
			rf_q     <= rf_n;
			lf_q     <= lf_n;
			deb_q    <= deb_n;
			hold_q   <= hold_n;
			page_q   <= page_n;
			rage_q   <= rage_n;
		end
	end

	assign flags_next.down      = stable_n;
	assign flags_next.pressed   = pf_n;
	assign flags_next.released  = rf_n;
	assign flags_next.held_long = lf_n;
	assign flags_next.taken     = taken_n;

endmodule

@@ dv/key_debounce_event_detector_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the key debounce and event detector.
module key_debounce_event_detector_tb;
	import kde_pkg::*;

	localparam int                   KEYS        = 4;
	localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
	localparam logic [CFG_W-1:0]     COUNT_TOP   = 16'hFFFF;
	localparam int                   HOLD_OFF    = 80;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;    // key_index [1:0], raw_pins [5:2]
	logic [KIND_W-1:0]      s_tuser;    // kind [1:0]
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;    // down [3:0], pressed [7:4], released [11:8],
	                                    // long [15:12], taken [16]
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	key_debounce_event_detector #(
		.NUM_KEYS    (KEYS),
		.COUNT_WIDTH (16)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Key model: its own copy of the timing registers and per-key state
	// ---------------------------------------------------------------
	logic [STEP_W-1:0] step_ms;
	logic [CFG_W-1:0]  debounce_lim;
	logic [CFG_W-1:0]  press_hold_lim;
	logic [CFG_W-1:0]  release_hold_lim;
	logic [CFG_W-1:0]  long_lim;

	bit [KEYS-1:0]     stable_q;
	bit [KEYS-1:0]     prev_q;
	bit [KEYS-1:0]     press_q;
	bit [KEYS-1:0]     release_q;
	bit [KEYS-1:0]     long_q;
	logic [CFG_W-1:0]  settle_cnt   [KEYS];
	logic [CFG_W-1:0]  hold_cnt     [KEYS];
	logic [CFG_W-1:0]  press_age    [KEYS];
	logic [CFG_W-1:0]  release_age  [KEYS];

	// reports still to come out of the block, oldest first
	kde_result_t awaited_reports [$];

	// run bookkeeping
	int mismatches    = 0;
	int items_sent    = 0;
	int reports_seen  = 0;
	int takes_hit     = 0;
	int long_reports  = 0;

	// sender and receiver shaping
	int burst_left    = 0;
	int gap_max       = 4;
	int rx_mode       = 1;   // 0: always ready, 1: stall pattern
	int hold_off_left = 0;   // long hold-off, counted down by the receiver

	// wanted key levels for the random traffic (1 = held down)
	bit [KEYS-1:0] aim_down;

	// Advance a counter by one scan step; clamp at all ones.
	function automatic logic [CFG_W-1:0] add_step(input logic [CFG_W-1:0] c);
		logic [CFG_W:0] s;
		s = {1'b0, c} + {{(CFG_W + 1 - STEP_W){1'b0}}, step_ms};
		return s[CFG_W] ? COUNT_TOP : s[CFG_W-1:0];
	endfunction

	// Apply one input item to the key model and return the report it causes.
	function automatic kde_result_t next_key_report(input logic [KIND_W-1:0] kind,
			input logic [KEY_W-1:0] key, input logic [PIN_BITS-1:0] pins);
		kde_result_t r;
		bit          raw;
		r = '0;
		if (kind == KIND_SCAN) begin
			for (int k = 0; k < KEYS; k++) begin
				// pins are active low
				raw = !pins[k];
				if (raw == stable_q[k]) begin
					settle_cnt[k] = '0;
				end else begin
					settle_cnt[k] = add_step(settle_cnt[k]);
					if (settle_cnt[k] >= debounce_lim) begin
						stable_q[k]   = raw;
						settle_cnt[k] = '0;
					end
				end
				if (!prev_q[k] && stable_q[k]) begin
					press_q[k]   = 1'b1;
					press_age[k] = '0;
				end
				if (prev_q[k] && !stable_q[k]) begin
					release_q[k]   = 1'b1;
					release_age[k] = '0;
				end
				// the setting tick already counts towards the age
				if (press_q[k]) begin
					press_age[k] = add_step(press_age[k]);
					if (press_age[k] >= press_hold_lim)
						press_q[k] = 1'b0;
				end
				if (release_q[k]) begin
					release_age[k] = add_step(release_age[k]);
					if (release_age[k] >= release_hold_lim)
						release_q[k] = 1'b0;
				end
				prev_q[k] = stable_q[k];
				if (stable_q[k]) begin
					hold_cnt[k] = add_step(hold_cnt[k]);
					if (hold_cnt[k] >= long_lim)
						long_q[k] = 1'b1;
				end else begin
					hold_cnt[k] = '0;
					long_q[k]   = 1'b0;
				end
			end
		end else if (kind == KIND_TAKE_PRESSED) begin
			if (press_q[key]) begin
				press_q[key] = 1'b0;
				r.taken      = 1'b1;
			end
		end else if (kind == KIND_TAKE_RELEASED) begin
			if (release_q[key]) begin
				release_q[key] = 1'b0;
				r.taken        = 1'b1;
			end
		end
		// the unused kind leaves everything as it is
		r.down_mask     = stable_q;
		r.pressed_mask  = press_q;
		r.released_mask = release_q;
		r.long_mask     = long_q;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Sender: bursts of random length, random gaps between them
	// ---------------------------------------------------------------
	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
			input logic [PIN_BITS-1:0] pins);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(gap_max, 0);
			burst_left = $urandom_range(16, 1);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		// keep tvalid high across back-to-back transactions
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, pins, key};
		do @(posedge clk); while (!s_tready);
		awaited_reports.push_back(next_key_report(kind, key, pins));
		burst_left--;
		items_sent++;
	endtask

	// Stop sending and hold until every report has come back, plus a margin.
	task automatic wait_drained();
		s_tvalid   <= 1'b0;
		burst_left  = 0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; the model takes the value at the handshake.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SCAN_STEP:     step_ms          = val[STEP_W-1:0];
			REG_DEBOUNCE:      debounce_lim     = val;
			REG_PRESSED_HOLD:  press_hold_lim   = val;
			REG_RELEASED_HOLD: release_hold_lim = val;
			REG_LONG_PRESS:    long_lim         = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Rewrite the whole timing set; call only once the block has drained.
	task automatic set_timing(input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] deb,
			input logic [CFG_W-1:0] p_hold, input logic [CFG_W-1:0] r_hold,
			input logic [CFG_W-1:0] lp);
		write_reg(REG_SCAN_STEP, step);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_PRESSED_HOLD, p_hold);
		write_reg(REG_RELEASED_HOLD, r_hold);
		write_reg(REG_LONG_PRESS, lp);
	endtask

	// Scan ticks with a fixed pin pattern, a hold-off at one chosen tick.
	task automatic hold_pins(input int n, input logic [PIN_BITS-1:0] pins, input int hold_at);
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				hold_off_left = HOLD_OFF;
			// now and then drop in an ignored item
			if ($urandom_range(29, 0) == 0)
				send_item(KIND_UNUSED, KEY_W'($urandom), PIN_BITS'($urandom));
			send_item(KIND_SCAN, KEY_W'($urandom), pins);
		end
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Field extremes, every kind, zero thresholds and a zero scan step.
	task automatic test_directed_cases();
		rx_mode = 0;
		gap_max = 2;
		// defaults: an empty take, then a press that needs two ticks
		send_item(KIND_SCAN, 2'd0, 4'hF);
		send_item(KIND_TAKE_PRESSED, 2'd0, 4'h0);
		send_item(KIND_TAKE_RELEASED, 2'd3, 4'hF);
		send_item(KIND_UNUSED, 2'd2, 4'hA);
		send_item(KIND_SCAN, 2'd3, 4'h0);
		send_item(KIND_SCAN, 2'd1, 4'h0);
		send_item(KIND_TAKE_PRESSED, 2'd1, 4'h5);
		send_item(KIND_TAKE_PRESSED, 2'd1, 4'h0);
		wait_drained();
		// zero debounce and zero pressed hold: follow at once, clear on the setting tick
		set_timing(16'd1, 16'd0, 16'd0, 16'd2, 16'd0);
		send_item(KIND_SCAN, 2'd0, 4'hF);
		send_item(KIND_TAKE_RELEASED, 2'd2, 4'hF);
		send_item(KIND_SCAN, 2'd2, 4'h0);
		send_item(KIND_TAKE_PRESSED, 2'd0, 4'h0);
		send_item(KIND_SCAN, 2'd1, 4'h5);
		wait_drained();
		// zero scan step: counters stand still
		write_reg(REG_SCAN_STEP, 16'd0);
		write_reg(REG_DEBOUNCE, 16'd5);
		send_item(KIND_SCAN, 2'd0, 4'hA);
		send_item(KIND_SCAN, 2'd3, 4'hA);
		send_item(KIND_SCAN, 2'd2, 4'hF);
		send_item(KIND_TAKE_RELEASED, 2'd1, 4'h0);
		wait_drained();
	endtask

	// Largest limits: every counter must run into its ceiling.
	task automatic test_counter_saturation();
		rx_mode = 1;
		gap_max = 3;
		// step 254 overshoots the ceiling, so the debounce count clamps
		set_timing(16'd254, COUNT_TOP, COUNT_TOP, COUNT_TOP, COUNT_TOP);
		hold_pins(270, 4'h0, 150);
		// pause the sender until all reports are in, then release keys 2 and 3
		wait_drained();
		write_reg(REG_SCAN_STEP, 16'd255);
		write_reg(REG_DEBOUNCE, 16'd255);
		hold_pins(280, 4'hC, -1);
		wait_drained();
	endtask

	// Random key traffic: clean presses and releases with bounce, plus takes and noise.
	task automatic test_random_traffic(input int n, input bit wide, input int gaps,
			input int rx, input int hold_at);
		int                   roll;
		logic [PIN_BITS-1:0]  pins;
		rx_mode = rx;
		gap_max = gaps;
		if (wide)
			set_timing(CFG_W'($urandom_range(255, 1)), CFG_W'($urandom_range(600, 0)),
				CFG_W'($urandom_range(1500, 0)), CFG_W'($urandom_range(1500, 0)),
				CFG_W'($urandom_range(1500, 0)));
		else
			set_timing(CFG_W'($urandom_range(20, 1)), CFG_W'($urandom_range(80, 0)),
				CFG_W'($urandom_range(200, 0)), CFG_W'($urandom_range(200, 0)),
				CFG_W'($urandom_range(300, 0)));
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				hold_off_left = HOLD_OFF;
			roll = $urandom_range(99, 0);
			if (roll < 4) begin
				send_item(KIND_UNUSED, KEY_W'($urandom), PIN_BITS'($urandom));
			end else if (roll < 28) begin
				send_item(roll[0] ? KIND_TAKE_PRESSED : KIND_TAKE_RELEASED,
					KEY_W'($urandom), PIN_BITS'($urandom));
			end else begin
				for (int k = 0; k < KEYS; k++) begin
					if ($urandom_range(11, 0) == 0)
						aim_down[k] = !aim_down[k];
					// low pin for a held key, with an occasional bounce
					pins[k] = !aim_down[k] ^ ($urandom_range(9, 0) == 0);
				end
				send_item(KIND_SCAN, KEY_W'($urandom), pins);
			end
		end
		wait_drained();
	endtask

	// ---------------------------------------------------------------
	// Receiver: stall pattern of its own, plus the long hold-off
	// ---------------------------------------------------------------
	initial begin
		int run_left;
		bit rx_ready;
		run_left = 0;
		rx_ready = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				rx_ready = 1'b0;
				hold_off_left--;
			end else if (rx_mode == 0) begin
				rx_ready = 1'b1;
			end else begin
				if (run_left == 0) begin
					rx_ready = !rx_ready;
					run_left = rx_ready ? $urandom_range(8, 1) : $urandom_range(4, 1);
				end
				run_left--;
			end
			m_tready <= rx_ready;
		end
	end

	// ---------------------------------------------------------------
	// Checker: compare each report transaction with the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		kde_result_t got;
		kde_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[RESULT_W-1:0];
			reports_seen++;
			if (got.taken === 1'b1)
				takes_hit++;
			if (got.long_mask !== '0)
				long_reports++;
			if (awaited_reports.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: report with nothing awaited: %h", $realtime, m_tdata);
				mismatches++;
			end else begin
				want = awaited_reports.pop_front();
				if (got.down_mask !== want.down_mask ||
						got.pressed_mask !== want.pressed_mask ||
						got.released_mask !== want.released_mask ||
						got.long_mask !== want.long_mask || got.taken !== want.taken) begin
					if (mismatches < 10)
						$display({"%0t: report %0d mismatch (expected/actual): ",
							"down %h/%h pressed %h/%h released %h/%h long %h/%h taken %b/%b"},
							$realtime, reports_seen,
							want.down_mask, got.down_mask, want.pressed_mask, got.pressed_mask,
							want.released_mask, got.released_mask,
							want.long_mask, got.long_mask, want.taken, got.taken);
					mismatches++;
				end
			end
		end
	end

	// Give up well past the slowest correct run.
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		aim_down  = '0;
		// model state after reset: registers at their defaults, every key released
		step_ms          = RST_SCAN_STEP;
		debounce_lim     = RST_DEBOUNCE;
		press_hold_lim   = RST_PRESSED_HOLD;
		release_hold_lim = RST_RELEASED_HOLD;
		long_lim         = RST_LONG_PRESS;
		stable_q  = '0;
		prev_q    = '0;
		press_q   = '0;
		release_q = '0;
		long_q    = '0;
		for (int k = 0; k < KEYS; k++) begin
			settle_cnt[k]  = '0;
			hold_cnt[k]    = '0;
			press_age[k]   = '0;
			release_age[k] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_counter_saturation();
		test_random_traffic(100, 1'b0, 4, 1, 40);
		test_random_traffic(100, 1'b0, 0, 0, -1);
		test_random_traffic(100, 1'b1, 4, 1, -1);
		wait_drained();
		repeat (10) @(posedge clk);

		$display("Summary: %0d items sent, %0d reports checked, %0d takes cleared a flag,",
			items_sent, reports_seen, takes_hit);
		$display("Summary: %0d reports with a long press over directed, saturation and random runs.",
			long_reports);
		if (mismatches == 0 && awaited_reports.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
